// ===== src/wildcard_word_signature_scan_defines.svh =====
// Assertion macros shared by the signature scanner RTL
`ifndef WILDCARD_WORD_SIGNATURE_SCAN_DEFINES_SVH
`define WILDCARD_WORD_SIGNATURE_SCAN_DEFINES_SVH

// Checked on every rising edge, masked while reset is asserted
`define WWSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included
`define WWSS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/wwss_pkg.sv =====
// Package: constants and types of the wildcard word signature scanner
package wwss_pkg;

  localparam int PATTERN_MAX_DEF = 32;

  localparam int LEN_W   = 6;
  localparam int LIMIT_W = 8;
  localparam int IDX_W   = 5;
  localparam int WORD_W  = 32;
  localparam int CFG_W   = 8;

  // request types
  localparam logic REQ_SCAN = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  // configuration register indexes
  localparam logic CFG_PATTERN_LENGTH = 1'b0;
  localparam logic CFG_MATCH_LIMIT    = 1'b1;

  // pattern code encodings
  localparam logic [31:0] CODE_WILD    = 32'h0000_0011;
  localparam logic [31:0] CODE_NONZERO = 32'h0000_0022;
  localparam logic [31:0] HI_MASK      = 32'hffff_0000;
  localparam logic [31:0] HI_KEY       = 32'h1234_0000;
  localparam logic [31:0] LO_MASK      = 32'h0000_ffff;
  localparam logic [31:0] LO_KEY       = 32'h0000_1234;
  localparam logic [31:0] REF_MASK     = 32'h0000_ff00;
  localparam logic [31:0] REF_KEY      = 32'h0000_1100;
  localparam logic [31:0] REF_IDX_MASK = 32'h0000_00ff;

  typedef struct packed {
    logic [LEN_W-1:0]   pattern_length;
    logic [LIMIT_W-1:0] match_limit;
  } cfg_t;

endpackage

// ===== src/wwss_match.sv =====
// Window compare: tests the newest window words against the pattern table
module wwss_match #(
  parameter int PATTERN_MAX = wwss_pkg::PATTERN_MAX_DEF,
  parameter int CW          = 6
) (
  input  logic [wwss_pkg::LEN_W-1:0]  len,
  input  logic [wwss_pkg::WORD_W-1:0] tbl [PATTERN_MAX],
  input  logic [wwss_pkg::WORD_W-1:0] wv  [PATTERN_MAX],
  output logic                        window_hit
);

  localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int KW = (CW > 8) ? CW : 8;

  logic [PATTERN_MAX-1:0] fail;

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_slot
    logic [CW-1:0]   len_c;
    logic [CW-1:0]   age;
    logic [KW-1:0]   len_k;
    logic [KW-1:0]   k;
    logic [KW-1:0]   ref_age;
    logic [31:0]     code;
    logic [31:0]     w;
    logic [31:0]     ref_w;
    logic            active;
    logic            ok;

    always_comb begin
      len_c   = CW'(len);
      age     = len_c - CW'(1) - CW'(j);
      len_k   = KW'(len);
      code    = tbl[j];
      k       = KW'(code & wwss_pkg::REF_IDX_MASK);
      ref_age = len_k - KW'(1) - k;
      w       = wv[age[IW-1:0]];
      ref_w   = wv[ref_age[IW-1:0]];
      active  = CW'(j) < len_c;
      if (code == wwss_pkg::CODE_WILD) begin
        ok = 1'b1;
      end else if (code == wwss_pkg::CODE_NONZERO) begin
        ok = (w != '0);
      end else if ((code & wwss_pkg::HI_MASK) == wwss_pkg::HI_KEY) begin
        ok = ((w & wwss_pkg::LO_MASK) == (code & wwss_pkg::LO_MASK));
      end else if ((code & wwss_pkg::LO_MASK) == wwss_pkg::LO_KEY) begin
        ok = ((w & wwss_pkg::HI_MASK) == (code & wwss_pkg::HI_MASK));
      end else if ((code & wwss_pkg::REF_MASK) == wwss_pkg::REF_KEY) begin
        ok = (k < len_k) && (w == ref_w);
      end else begin
        ok = (w == code);
      end
      fail[j] = active && !ok;
    end
  end

  assign window_hit = ~|fail;

endmodule

// ===== src/wildcard_word_signature_scan.sv =====
// Top level: wildcard word signature scanner over a stream of memory words
// Datapath: an input transaction passes the input register, then the result register.
// Throughput: one transaction per cycle, loads and scans alike; only a stalled
//   result register holds the input side.
// Reset (rst_n, synchronous): clears handshake state, window fill, match count and
//   stop flag, sets pattern length 0 and match limit 1; pattern table and window undefined until written.
`include "wildcard_word_signature_scan_defines.svh"

module wildcard_word_signature_scan #(
  parameter int PATTERN_MAX = wwss_pkg::PATTERN_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [wwss_pkg::CFG_W-1:0]    cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [wwss_pkg::IDX_W-1:0]    in_pattern_index,
  input  logic [wwss_pkg::WORD_W-1:0]   in_pattern_code,
  input  logic [wwss_pkg::WORD_W-1:0]   in_mem_word,
  input  logic [wwss_pkg::WORD_W-1:0]   in_word_addr,
  input  logic                          in_last_word,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wwss_pkg::WORD_W-1:0]   out_match_addr,
  output logic [wwss_pkg::LIMIT_W-1:0]  out_match_ordinal,
  output logic                          out_limit_reached
);

  localparam int FW  = $clog2(PATTERN_MAX + 1);
  localparam int CW  = (FW > wwss_pkg::LEN_W) ? FW : wwss_pkg::LEN_W;
  localparam int XW  = ((PATTERN_MAX > 1) && ($clog2(PATTERN_MAX) > wwss_pkg::IDX_W)) ?
                       $clog2(PATTERN_MAX) : wwss_pkg::IDX_W;
  localparam int WD  = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;

  wwss_pkg::cfg_t cfg_r;

  // input register
  logic                          s1_v_r;
  logic                          s1_req_r;
  logic [wwss_pkg::IDX_W-1:0]    s1_idx_r;
  logic [wwss_pkg::WORD_W-1:0]   s1_code_r;
  logic [wwss_pkg::WORD_W-1:0]   s1_word_r;
  logic [wwss_pkg::WORD_W-1:0]   s1_addr_r;
  logic                          s1_last_r;

  // scan state
  logic [wwss_pkg::WORD_W-1:0]   tbl_r [PATTERN_MAX];
  logic [wwss_pkg::WORD_W-1:0]   win_r [WD];
  logic [FW-1:0]                 fill_r;
  logic [wwss_pkg::LIMIT_W-1:0]  count_r;
  logic                          stopped_r;

  // result register
  logic                          out_valid_r;
  logic [wwss_pkg::WORD_W-1:0]   out_addr_r;
  logic [wwss_pkg::LIMIT_W-1:0]  out_ord_r;
  logic                          out_reached_r;

  logic [wwss_pkg::WORD_W-1:0]   wv [PATTERN_MAX];
  logic                          adv;
  logic                          fire;
  logic                          scan;
  logic                          load;
  logic                          window_hit;
  logic [FW-1:0]                 fill_nxt;
  logic                          len_ok;
  logic                          hit;
  logic [wwss_pkg::LIMIT_W-1:0]  count_inc;
  logic                          reached;
  logic [wwss_pkg::WORD_W-1:0]   addr_nxt;
  logic [XW-1:0]                 s1_idx_ext;
  logic                          ord_at_limit;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_v_r && !adv;
  assign fire     = s1_v_r && adv;
  assign scan     = fire && (s1_req_r == wwss_pkg::REQ_SCAN);
  assign load     = fire && (s1_req_r == wwss_pkg::REQ_LOAD);

  // window as seen with the incoming word at age zero
  always_comb begin
    wv[0] = s1_word_r;
    for (int a = 1; a < PATTERN_MAX; a++) begin
      wv[a] = win_r[a-1];
    end
  end

  wwss_match #(
    .PATTERN_MAX (PATTERN_MAX),
    .CW          (CW)
  ) u_match (
    .len        (cfg_r.pattern_length),
    .tbl        (tbl_r),
    .wv         (wv),
    .window_hit (window_hit)
  );

  always_comb begin
    fill_nxt   = (fill_r < FW'(PATTERN_MAX)) ? fill_r + FW'(1) : fill_r;
    len_ok     = (cfg_r.pattern_length != '0) &&
                 (CW'(cfg_r.pattern_length) <= CW'(PATTERN_MAX));
    hit        = scan && len_ok && (cfg_r.match_limit != '0) && !stopped_r &&
                 (count_r < cfg_r.match_limit) &&
                 (CW'(fill_nxt) >= CW'(cfg_r.pattern_length)) && window_hit;
    count_inc  = count_r + wwss_pkg::LIMIT_W'(1);
    reached    = (count_inc >= cfg_r.match_limit);
    addr_nxt   = s1_addr_r -
                 (wwss_pkg::WORD_W'(cfg_r.pattern_length - wwss_pkg::LEN_W'(1)) << 2);
    s1_idx_ext = XW'(s1_idx_r);
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_length <= '0;
      cfg_r.match_limit    <= wwss_pkg::LIMIT_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        wwss_pkg::CFG_PATTERN_LENGTH: cfg_r.pattern_length <= cfg_data[wwss_pkg::LEN_W-1:0];
        wwss_pkg::CFG_MATCH_LIMIT:    cfg_r.match_limit    <= cfg_data[wwss_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!in_stall) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_r  <= in_req_type;
      s1_idx_r  <= in_pattern_index;
      s1_code_r <= in_pattern_code;
      s1_word_r <= in_mem_word;
      s1_addr_r <= in_word_addr;
      s1_last_r <= in_last_word;
    end
  end

  // pattern table and window storage
  always_ff @(posedge clk) begin
    for (int s = 0; s < PATTERN_MAX; s++) begin
      if (load && (s1_idx_ext == XW'(s))) begin
        tbl_r[s] <= s1_code_r;
      end
    end
    if (scan) begin
      for (int a = 0; a < WD; a++) begin
        win_r[a] <= wv[a];
      end
    end
  end

  // region state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      count_r   <= '0;
      stopped_r <= 1'b0;
    end else if (scan) begin
      if (s1_last_r) begin
        fill_r    <= '0;
        count_r   <= '0;
        stopped_r <= 1'b0;
      end else begin
        fill_r <= fill_nxt;
        if (hit) begin
          count_r <= count_inc;
          if (reached) begin
            stopped_r <= 1'b1;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      out_addr_r    <= addr_nxt;
      out_ord_r     <= count_inc;
      out_reached_r <= reached;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_match_addr    = out_addr_r;
  assign out_match_ordinal = out_ord_r;
  assign out_limit_reached = out_reached_r;

  assign ord_at_limit = (out_ord_r == cfg_r.match_limit);

  `WWSS_ASSERT(a_ord_nonzero, out_valid_r |-> (out_ord_r != '0), "match ordinal is zero")
  `WWSS_ASSERT(a_limit_flag, out_valid_r |-> (out_reached_r == ord_at_limit), "limit flag wrong")
  `WWSS_ASSERT(a_fill_bound, fill_r <= FW'(PATTERN_MAX), "window fill beyond depth")
  `WWSS_ASSERT_ALWAYS(a_stall_src, in_stall |-> s1_v_r, "input stalled with empty input register")

endmodule
